// File: hw/rtl/pcbh_pkg.sv
// ----------------------------------------------------------------------------
// Per-cycle base histogram package
// Shared widths, codes, states and the base classifier.
// ----------------------------------------------------------------------------
package pcbh_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned CharW      = 8;
  localparam int unsigned PosW       = 9;
  localparam int unsigned FieldW     = 32;
  localparam int unsigned SeenW      = 10;
  localparam int unsigned NClass     = 5;
  localparam int unsigned ClsW       = 3;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 208;
  localparam int unsigned OutUsedW   = NClass * FieldW + FieldW + SeenW + 1;

  localparam int unsigned MaxPositionsDef = 512;
  localparam int unsigned CountWidthDef   = 32;

  localparam logic [CharW-1:0] ChA = 8'd65;
  localparam logic [CharW-1:0] ChT = 8'd84;
  localparam logic [CharW-1:0] ChC = 8'd67;
  localparam logic [CharW-1:0] ChG = 8'd71;
  localparam logic [CharW-1:0] ChLowA = 8'd97;
  localparam logic [CharW-1:0] ChLowZ = 8'd122;
  localparam logic [CharW-1:0] CaseGap = 8'd32;

  typedef enum logic [OpW-1:0] {
    OP_COUNT    = 2'd0,
    OP_READ_POS = 2'd1,
    OP_READ_TOT = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [ClsW-1:0] {
    CLS_A = 3'd0,
    CLS_T = 3'd1,
    CLS_C = 3'd2,
    CLS_G = 3'd3,
    CLS_N = 3'd4
  } cls_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_RESP
  } state_e;

  function automatic cls_e classify(input logic [CharW-1:0] ch);
    logic [CharW-1:0] up;
    cls_e             cls;
    up = ((ch >= ChLowA) && (ch <= ChLowZ)) ? ch - CaseGap : ch;
    if (up == ChA) begin
      cls = CLS_A;
    end else if (up == ChT) begin
      cls = CLS_T;
    end else if (up == ChC) begin
      cls = CLS_C;
    end else if (up == ChG) begin
      cls = CLS_G;
    end else begin
      cls = CLS_N;
    end
    return cls;
  endfunction

endpackage

// File: hw/rtl/pcbh_ram.sv
// ----------------------------------------------------------------------------
// Per-cycle base histogram RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pcbh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/per_cycle_base_histogram.sv
// ----------------------------------------------------------------------------
// Per-cycle base histogram
// Counts bases per sequencing cycle and class, and answers count queries.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (lowest bit up)               | tuser
//  s_axis   | in        | base_char[7:0], position[16:8]      | op[1:0]
//  m_axis   | out       | count_a..count_n, total_bases,      | -
//           |           | positions_seen, overflow_seen       |
//
// A count item within the store reads its row of the counter RAM, then
// writes back the incremented row. One beyond the store needs no RAM access.
// A query waits in the response state for the output register.
// After reset a clearing pass zeroes the counter RAM and takes no transfer.
// A stalled output holds a query, during which no transfer is taken;
// count items are still taken while no query waits on the output.
// ----------------------------------------------------------------------------
module per_cycle_base_histogram #(
  parameter int unsigned MAX_POSITIONS = pcbh_pkg::MaxPositionsDef,
  parameter int unsigned COUNT_WIDTH   = pcbh_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // base_char [7:0], position [16:8], zero fill
  input  logic [pcbh_pkg::InDataW-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [pcbh_pkg::OpW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // count_a [31:0], count_t [63:32], count_c [95:64], count_g [127:96],
  // count_n [159:128], total_bases [191:160], positions_seen [201:192],
  // overflow_seen [202], zero fill
  output logic [pcbh_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int unsigned RamW  = pcbh_pkg::NClass * COUNT_WIDTH;
  localparam int unsigned PosW  = pcbh_pkg::PosW;
  localparam int unsigned SeenW = pcbh_pkg::SeenW;
  localparam int unsigned FW    = pcbh_pkg::FieldW;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [FW-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+FW-1:0] w;
    w = {{FW{1'b0}}, v};
    return w[FW-1:0];
  endfunction

  pcbh_pkg::state_e state_q, state_d;

  logic                      accept;
  pcbh_pkg::op_e             in_op;
  logic [pcbh_pkg::CharW-1:0] in_char;
  logic [PosW-1:0]           in_pos;
  logic [AW+PosW-1:0]        in_pos_ext;
  logic [AW-1:0]             in_addr;
  logic                      in_stored;
  pcbh_pkg::cls_e            in_cls;
  logic [SeenW-1:0]          in_seen;

  logic [AW-1:0]             clr_q;
  logic                      clr_last;
  logic [AW-1:0]             addr_q;
  pcbh_pkg::cls_e            cls_q;
  logic                      stored_q;
  pcbh_pkg::op_e             op_q;

  logic [COUNT_WIDTH-1:0]    class_tot_q [pcbh_pkg::NClass];
  logic [COUNT_WIDTH-1:0]    base_tot_q;
  logic [SeenW-1:0]          seen_q;
  logic                      ovf_q;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [RamW-1:0]           ram_wdata;
  logic                      ram_re;
  logic [RamW-1:0]           ram_rdata;
  logic [RamW-1:0]           row_inc;

  logic                      res_load;
  logic                      out_valid_q;
  logic [pcbh_pkg::OutDataW-1:0] out_data_q, out_data_d;

  assign in_op      = pcbh_pkg::op_e'(s_axis_tuser);
  assign in_char    = s_axis_tdata[7:0];
  assign in_pos     = s_axis_tdata[16:8];
  assign in_pos_ext = {{AW{1'b0}}, in_pos};
  assign in_addr    = in_pos_ext[AW-1:0];
  assign in_stored  = (in_pos_ext < (AW+PosW)'(MAX_POSITIONS));
  assign in_cls     = pcbh_pkg::classify(in_char);
  assign in_seen    = {1'b0, in_pos} + 1'b1;
  assign clr_last   = (clr_q == AW'(MAX_POSITIONS - 1));

  assign s_axis_tready = (state_q == pcbh_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int k = 0; k < pcbh_pkg::NClass; k++) begin
      if (cls_q == pcbh_pkg::cls_e'(k)) begin
        row_inc[k*COUNT_WIDTH +: COUNT_WIDTH] = sat_inc(ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH]);
      end else begin
        row_inc[k*COUNT_WIDTH +: COUNT_WIDTH] = ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcbh_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = pcbh_pkg::ST_IDLE;
        end
      end
      pcbh_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            pcbh_pkg::OP_COUNT: begin
              if (in_stored) begin
                state_d = pcbh_pkg::ST_UPDATE;
              end
            end
            pcbh_pkg::OP_READ_POS,
            pcbh_pkg::OP_READ_TOT: state_d = pcbh_pkg::ST_RESP;
            pcbh_pkg::OP_NONE:     state_d = pcbh_pkg::ST_IDLE;
          endcase
        end
      end
      pcbh_pkg::ST_UPDATE: state_d = pcbh_pkg::ST_IDLE;
      pcbh_pkg::ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = pcbh_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = row_inc;
    ram_re    = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      pcbh_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      pcbh_pkg::ST_IDLE: begin
        ram_re = accept && in_stored &&
                 ((in_op == pcbh_pkg::OP_COUNT) || (in_op == pcbh_pkg::OP_READ_POS));
      end
      pcbh_pkg::ST_UPDATE: ram_we = 1'b1;
      pcbh_pkg::ST_RESP:   res_load = !out_valid_q || m_axis_tready;
    endcase
  end

  pcbh_ram #(
    .Width (RamW),
    .Depth (MAX_POSITIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_data_d = '0;
    for (int k = 0; k < pcbh_pkg::NClass; k++) begin
      if (op_q == pcbh_pkg::OP_READ_TOT) begin
        out_data_d[k*FW +: FW] = to_field(class_tot_q[k]);
      end else if (stored_q) begin
        out_data_d[k*FW +: FW] = to_field(ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH]);
      end
    end
    out_data_d[pcbh_pkg::NClass*FW +: FW]      = to_field(base_tot_q);
    out_data_d[(pcbh_pkg::NClass+1)*FW +: SeenW] = seen_q;
    out_data_d[pcbh_pkg::OutUsedW-1]           = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcbh_pkg::ST_CLEAR;
      clr_q       <= '0;
      base_tot_q  <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < pcbh_pkg::NClass; k++) begin
        class_tot_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == pcbh_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept && (in_op == pcbh_pkg::OP_COUNT)) begin
        base_tot_q          <= sat_inc(base_tot_q);
        class_tot_q[in_cls] <= sat_inc(class_tot_q[in_cls]);
        if (!in_stored) begin
          ovf_q <= 1'b1;
        end else if (in_seen > seen_q) begin
          seen_q <= in_seen;
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= in_addr;
      cls_q    <= in_cls;
      stored_q <= in_stored;
      op_q     <= in_op;
    end
    if (res_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == pcbh_pkg::ST_UPDATE) || (state_q == pcbh_pkg::ST_CLEAR))
    else $error("Counter RAM written outside clearing or update.");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenW'(MAX_POSITIONS))
    else $error("Positions seen exceeds the store depth.");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("Overflow flag cleared without reset.");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || m_axis_tready))
    else $error("Result loaded over an untaken transfer.");

  a_update_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcbh_pkg::ST_UPDATE) |-> $past(ram_re))
    else $error("Row update without a preceding read.");
`endif

endmodule
